// ----- hdl/priority_thread_scheduler_macros.svh -----
// assertion macros for the priority thread scheduler
`ifndef PRIORITY_THREAD_SCHEDULER_MACROS_SVH
`define PRIORITY_THREAD_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define PTS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pts_pkg.sv -----
// shared types and constants of the priority thread scheduler
package pts_pkg;

   localparam int THREAD_SLOTS_DEF = 16;
   localparam int EVENT_SLOTS_DEF  = 8;
   localparam int REQ_W  = 3;
   localparam int PRIO_W = 8;
   localparam int ID_W   = 20;
   localparam int TIME_W = 32;
   localparam int IDC_W  = 16;
   localparam int STAT_W = 2;
   localparam logic [PRIO_W-1:0] PRIO_BOUND = 8'd255;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 3'd0,
      REQ_SCHED  = 3'd1,
      REQ_ADD    = 3'd2,
      REQ_KILL   = 3'd3,
      REQ_KSELF  = 3'd4,
      REQ_SLEEP  = 3'd5,
      REQ_BLOCK  = 3'd6,
      REQ_PERIOD = 3'd7
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_LAST = 2'd2,
      ST_NONE = 2'd3
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   ident;
      logic [TIME_W-1:0] wake;
   } thr_entry_type;

   typedef struct packed {
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] due;
   } evt_entry_type;

endpackage

// ----- hdl/pts_req_if.sv -----
// request channel of the priority thread scheduler
interface pts_req_if;
   logic                       valid;
   logic                       ready;
   logic [pts_pkg::REQ_W-1:0]  req_type;
   logic [pts_pkg::PRIO_W-1:0] prio_value;
   logic [pts_pkg::ID_W-1:0]   target_id;
   logic                       block_value;
   logic [pts_pkg::TIME_W-1:0] sleep_ticks;
   logic [pts_pkg::TIME_W-1:0] period_ticks;

   modport source (output valid, req_type, prio_value, target_id, block_value,
                   sleep_ticks, period_ticks, input ready);
   modport sink (input valid, req_type, prio_value, target_id, block_value,
                 sleep_ticks, period_ticks, output ready);
endinterface

// ----- hdl/pts_rsp_if.sv -----
// response channel of the priority thread scheduler
interface pts_rsp_if #(
   parameter int SLOT_W = 4,
   parameter int EVT_W  = 3
);
   logic                       valid;
   logic                       ready;
   logic [pts_pkg::STAT_W-1:0] status;
   logic [SLOT_W-1:0]          running_slot;
   logic [pts_pkg::ID_W-1:0]   running_id;
   logic [pts_pkg::ID_W-1:0]   assigned_id;
   logic                       event_fired;
   logic [EVT_W-1:0]           event_index;
   logic                       switch_request;
   logic                       last;

   modport source (output valid, status, running_slot, running_id, assigned_id, event_fired,
                   event_index, switch_request, last, input ready);
   modport sink (input valid, status, running_slot, running_id, assigned_id, event_fired,
                 event_index, switch_request, last, output ready);
endinterface

// ----- hdl/priority_thread_scheduler.sv -----
// priority thread scheduler top level: thread and event tables with a scan sequencer
//
// usage:
// - req_bus carries one request per valid/ready handshake; ready is high only
//   while the sequencer is idle, so one request is worked on at a time
// - rsp_bus returns the responses of a request in order, the final one marked
//   with last; a tick gives one response per fired periodic event and a
//   closing one, every other request gives one response
// - schedule, kill thread and set blocked scan the thread table one slot a
//   cycle through the memory read port; add, kill self, sleep and add
//   periodic go straight to the final response; a tick checks each live
//   event in turn and then runs the wake scan over the thread table
// - the next request is taken once the final response has been registered
// - a stalled receiver holds the response register; the sequencer waits in
//   place until it drains, and a new request is taken while the last response
//   of the previous one still waits
// - reset (synchronous) clears time, counters, the current slot and the
//   per-slot alive, asleep and blocked flags; the tables need no clearing pass
`include "priority_thread_scheduler_macros.svh"

module priority_thread_scheduler #(
   parameter int THREAD_SLOTS = pts_pkg::THREAD_SLOTS_DEF,
   parameter int EVENT_SLOTS  = pts_pkg::EVENT_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pts_req_if.sink    req_bus,
   pts_rsp_if.source  rsp_bus
);

   localparam int SW  = $clog2(THREAD_SLOTS);
   localparam int CW  = $clog2(THREAD_SLOTS + 1);
   localparam int EW  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int ECW = $clog2(EVENT_SLOTS + 1);
   localparam int IDW = pts_pkg::ID_W;
   localparam int TW  = pts_pkg::TIME_W;
   localparam int PW  = pts_pkg::PRIO_W;

   typedef enum logic [2:0] {
      S_IDLE, S_TSCAN, S_TLAST, S_ERD, S_ECHK, S_FIN
   } state_type;

   state_type               state_ff;
   pts_pkg::req_code_type   op_ff;
   logic [PW-1:0]           prio_ff;
   logic [IDW-1:0]          target_ff;
   logic                    blk_ff;
   logic [TW-1:0]           sticks_ff;
   logic [TW-1:0]           period_ff;

   logic [TW-1:0]           time_ff;
   logic [SW-1:0]           cur_ff;
   logic [IDW-1:0]          cur_id_ff;
   logic [CW-1:0]           tcount_ff;
   logic [pts_pkg::IDC_W-1:0] idc_ff;
   logic [ECW-1:0]          ecount_ff;
   logic [THREAD_SLOTS-1:0] alive_ff;
   logic [THREAD_SLOTS-1:0] asleep_ff;
   logic [THREAD_SLOTS-1:0] blocked_ff;

   // scan sequencer
   logic [SW-1:0]           sl_ff;
   logic [SW-1:0]           cnt_ff;
   logic                    p_vld_ff;
   logic [SW-1:0]           p_slot_ff;
   logic [PW-1:0]           best_ff;
   logic                    found_ff;
   logic [SW-1:0]           pick_ff;
   logic [IDW-1:0]          pick_id_ff;
   logic [EW-1:0]           e_ff;

   // response register
   logic                    rsp_valid_ff;
   pts_pkg::status_type     rsp_status_ff;
   logic [SW-1:0]           rsp_slot_ff;
   logic [IDW-1:0]          rsp_run_id_ff;
   logic [IDW-1:0]          rsp_asg_id_ff;
   logic                    rsp_fired_ff;
   logic [EW-1:0]           rsp_evi_ff;
   logic                    rsp_sw_ff;
   logic                    rsp_last_ff;

   // tables
   pts_pkg::thr_entry_type  tmem [THREAD_SLOTS];
   pts_pkg::thr_entry_type  th_rd_ff;
   logic [SW-1:0]           th_addr;
   logic                    th_we;
   logic [SW-1:0]           th_waddr;
   pts_pkg::thr_entry_type  th_wdata;

   pts_pkg::evt_entry_type  emem [EVENT_SLOTS];
   pts_pkg::evt_entry_type  ev_rd_ff;
   logic                    ev_we;
   logic [EW-1:0]           ev_waddr;
   pts_pkg::evt_entry_type  ev_wdata;

   logic                    out_free;
   logic                    free_found;
   logic [SW-1:0]           free_slot;
   logic [IDW-1:0]          new_id;
   logic [SW-1:0]           cur_next;
   logic                    ev_due;
   logic                    ev_end;
   logic                    fin_go;
   logic                    count_ok;
   logic                    rsp_quiet;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign fin_go   = (state_ff == S_FIN) && out_free;
   assign cur_next = (cur_ff == SW'(THREAD_SLOTS - 1)) ? '0 : cur_ff + 1'b1;
   assign ev_due   = (ev_rd_ff.due == time_ff);
   assign ev_end   = ((ECW'(e_ff) + 1'b1) == ecount_ff);

   // lowest dead slot for a new thread
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
         if (!alive_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SW'(i);
         end
      end
   end

   // identifier is counter times slot range plus slot, kept to the id width
   assign new_id = IDW'({idc_ff, free_slot});

   // thread table port: scan address while scanning, else the current slot
   assign th_addr  = (state_ff == S_TSCAN) ? sl_ff : cur_ff;
   assign th_we    = fin_go && ((op_ff == pts_pkg::REQ_ADD && free_found) ||
                                op_ff == pts_pkg::REQ_SLEEP);
   assign th_waddr = (op_ff == pts_pkg::REQ_ADD) ? free_slot : cur_ff;
   always_comb begin
      if (op_ff == pts_pkg::REQ_ADD) begin
         th_wdata = '{prio: prio_ff, ident: new_id, wake: '0};
      end else begin
         th_wdata = '{prio: th_rd_ff.prio, ident: th_rd_ff.ident,
                      wake: sticks_ff + time_ff};
      end
   end

   always_ff @(posedge clock) begin
      th_rd_ff <= tmem[th_addr];
      if (th_we) begin
         tmem[th_waddr] <= th_wdata;
      end
   end

   // event table port: refresh a fired event or append a new one
   assign ev_we = ((state_ff == S_ECHK) && ev_due && out_free) ||
                  (fin_go && op_ff == pts_pkg::REQ_PERIOD &&
                   ecount_ff < ECW'(EVENT_SLOTS));
   assign ev_waddr = (state_ff == S_ECHK) ? e_ff : ecount_ff[EW-1:0];
   always_comb begin
      if (state_ff == S_ECHK) begin
         ev_wdata = '{period: ev_rd_ff.period, due: ev_rd_ff.period + time_ff};
      end else begin
         ev_wdata = '{period: period_ff, due: time_ff + 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ERD) begin
         ev_rd_ff <= emem[e_ff];
      end
      if (ev_we) begin
         emem[ev_waddr] <= ev_wdata;
      end
   end

   // sequencer, scan pipeline and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         cur_ff       <= '0;
         cur_id_ff    <= '0;
         tcount_ff    <= '0;
         idc_ff       <= '0;
         ecount_ff    <= '0;
         alive_ff     <= '0;
         asleep_ff    <= '0;
         blocked_ff   <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // one table entry per cycle, data arrives in the cycle after its address
         if (p_vld_ff) begin
            case (op_ff)
               pts_pkg::REQ_SCHED: begin
                  if (alive_ff[p_slot_ff] && !asleep_ff[p_slot_ff] &&
                      !blocked_ff[p_slot_ff] && th_rd_ff.prio < best_ff) begin
                     best_ff    <= th_rd_ff.prio;
                     pick_ff    <= p_slot_ff;
                     pick_id_ff <= th_rd_ff.ident;
                     found_ff   <= 1'b1;
                  end
               end
               pts_pkg::REQ_KILL, pts_pkg::REQ_BLOCK: begin
                  if (alive_ff[p_slot_ff] && th_rd_ff.ident == target_ff) begin
                     pick_ff  <= p_slot_ff;
                     found_ff <= 1'b1;
                  end
               end
               pts_pkg::REQ_TICK: begin
                  if (alive_ff[p_slot_ff] && asleep_ff[p_slot_ff] &&
                      th_rd_ff.wake == time_ff) begin
                     asleep_ff[p_slot_ff] <= 1'b0;
                  end
               end
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  op_ff     <= pts_pkg::req_code_type'(req_bus.req_type);
                  prio_ff   <= req_bus.prio_value;
                  target_ff <= req_bus.target_id;
                  blk_ff    <= req_bus.block_value;
                  sticks_ff <= req_bus.sleep_ticks;
                  period_ff <= req_bus.period_ticks;
                  best_ff   <= pts_pkg::PRIO_BOUND;
                  found_ff  <= 1'b0;
                  cnt_ff    <= '0;
                  e_ff      <= '0;
                  unique case (pts_pkg::req_code_type'(req_bus.req_type))
                     pts_pkg::REQ_TICK: begin
                        time_ff <= time_ff + 1'b1;
                        sl_ff   <= '0;
                        state_ff <= (ecount_ff != '0) ? S_ERD : S_TSCAN;
                     end
                     pts_pkg::REQ_SCHED: begin
                        sl_ff    <= cur_next;
                        state_ff <= S_TSCAN;
                     end
                     pts_pkg::REQ_KILL, pts_pkg::REQ_BLOCK: begin
                        sl_ff    <= '0;
                        state_ff <= S_TSCAN;
                     end
                     default: state_ff <= S_FIN;
                  endcase
               end
            end
            S_TSCAN: begin
               p_vld_ff  <= 1'b1;
               p_slot_ff <= sl_ff;
               sl_ff     <= (sl_ff == SW'(THREAD_SLOTS - 1)) ? '0 : sl_ff + 1'b1;
               cnt_ff    <= cnt_ff + 1'b1;
               if (cnt_ff == SW'(THREAD_SLOTS - 1)) begin
                  state_ff <= S_TLAST;
               end
            end
            S_TLAST: begin
               p_vld_ff <= 1'b0;
               state_ff <= S_FIN;
            end
            S_ERD: begin
               state_ff <= S_ECHK;
            end
            S_ECHK: begin
               if (!ev_due || out_free) begin
                  if (ev_due) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= pts_pkg::ST_OK;
                     rsp_slot_ff   <= cur_ff;
                     rsp_run_id_ff <= cur_id_ff;
                     rsp_asg_id_ff <= '0;
                     rsp_fired_ff  <= 1'b1;
                     rsp_evi_ff    <= e_ff;
                     rsp_sw_ff     <= 1'b0;
                     rsp_last_ff   <= 1'b0;
                  end
                  if (ev_end) begin
                     sl_ff    <= '0;
                     state_ff <= S_TSCAN;
                  end else begin
                     e_ff     <= e_ff + 1'b1;
                     state_ff <= S_ERD;
                  end
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= pts_pkg::ST_OK;
                  rsp_slot_ff   <= cur_ff;
                  rsp_run_id_ff <= cur_id_ff;
                  rsp_asg_id_ff <= '0;
                  rsp_fired_ff  <= 1'b0;
                  rsp_evi_ff    <= '0;
                  rsp_sw_ff     <= 1'b0;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
                  unique case (op_ff)
                     pts_pkg::REQ_TICK: rsp_sw_ff <= 1'b1;
                     pts_pkg::REQ_SCHED: begin
                        if (found_ff) begin
                           cur_ff        <= pick_ff;
                           cur_id_ff     <= pick_id_ff;
                           rsp_slot_ff   <= pick_ff;
                           rsp_run_id_ff <= pick_id_ff;
                        end
                     end
                     pts_pkg::REQ_ADD: begin
                        if (!free_found) begin
                           rsp_status_ff <= pts_pkg::ST_FULL;
                        end else begin
                           alive_ff[free_slot]   <= 1'b1;
                           asleep_ff[free_slot]  <= 1'b0;
                           blocked_ff[free_slot] <= 1'b0;
                           idc_ff        <= idc_ff + 1'b1;
                           tcount_ff     <= tcount_ff + 1'b1;
                           rsp_asg_id_ff <= new_id;
                           if (free_slot == cur_ff) begin
                              cur_id_ff     <= new_id;
                              rsp_run_id_ff <= new_id;
                           end
                        end
                     end
                     pts_pkg::REQ_KILL: begin
                        if (tcount_ff <= CW'(1)) begin
                           rsp_status_ff <= pts_pkg::ST_LAST;
                        end else if (!found_ff) begin
                           rsp_status_ff <= pts_pkg::ST_NONE;
                        end else begin
                           alive_ff[pick_ff] <= 1'b0;
                           tcount_ff <= tcount_ff - 1'b1;
                           rsp_sw_ff <= (cur_id_ff == target_ff);
                        end
                     end
                     pts_pkg::REQ_KSELF: begin
                        if (tcount_ff <= CW'(1)) begin
                           rsp_status_ff <= pts_pkg::ST_LAST;
                        end else if (!alive_ff[cur_ff]) begin
                           rsp_status_ff <= pts_pkg::ST_NONE;
                        end else begin
                           alive_ff[cur_ff] <= 1'b0;
                           tcount_ff <= tcount_ff - 1'b1;
                           rsp_sw_ff <= 1'b1;
                        end
                     end
                     pts_pkg::REQ_SLEEP: begin
                        asleep_ff[cur_ff] <= 1'b1;
                        rsp_sw_ff <= 1'b1;
                     end
                     pts_pkg::REQ_BLOCK: begin
                        if (!found_ff) begin
                           rsp_status_ff <= pts_pkg::ST_NONE;
                        end else begin
                           blocked_ff[pick_ff] <= blk_ff;
                        end
                     end
                     pts_pkg::REQ_PERIOD: begin
                        if (ecount_ff >= ECW'(EVENT_SLOTS)) begin
                           rsp_status_ff <= pts_pkg::ST_FULL;
                        end else begin
                           rsp_evi_ff <= ecount_ff[EW-1:0];
                           ecount_ff  <= ecount_ff + 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.running_slot   = rsp_slot_ff;
   assign rsp_bus.running_id     = rsp_run_id_ff;
   assign rsp_bus.assigned_id    = rsp_asg_id_ff;
   assign rsp_bus.event_fired    = rsp_fired_ff;
   assign rsp_bus.event_index    = rsp_evi_ff;
   assign rsp_bus.switch_request = rsp_sw_ff;
   assign rsp_bus.last           = rsp_last_ff;

   // helper terms for the checks below
   assign count_ok  = (tcount_ff == CW'($countones(alive_ff)));
   assign rsp_quiet = !rsp_valid_ff && state_ff != S_FIN && state_ff != S_ECHK;

   `PTS_ASSERT_IMP(a_count_matches, clock, reset, 1'b1, count_ok, "thread count mismatch")
   `PTS_ASSERT_IMP(a_cur_range, clock, reset, 1'b1, cur_ff <= SW'(THREAD_SLOTS - 1), "slot range")
   `PTS_ASSERT_IMP(a_ecount_range, clock, reset, 1'b1, ecount_ff <= ECW'(EVENT_SLOTS), "ecount")
   `PTS_ASSERT_NXT(a_rsp_source, clock, reset, rsp_quiet, !rsp_valid_ff, "stray response")

endmodule

// ----- verif/pts_tb_pkg.sv -----
`timescale 1ns / 100ps
// scoreboard class: behavioral scheduler model and expected-response store
package pts_tb_pkg;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  running_slot;
      logic [19:0] running_id;
      logic [19:0] assigned_id;
      logic        event_fired;
      logic [2:0]  event_index;
      logic        switch_request;
      logic        last;
   } sched_rsp_type;

   class sched_scoreboard;
      bit [31:0]  sys_time;
      bit [3:0]   cur_slot;
      int         thread_cnt;
      bit [15:0]  id_cnt;
      bit         alive [16];
      bit         asleep [16];
      bit         blocked [16];
      bit [7:0]   prio [16];
      bit [31:0]  wake [16];
      bit [19:0]  ident [16];
      int         evt_cnt;
      bit [31:0]  evt_period [8];
      bit [31:0]  evt_due [8];
      sched_rsp_type pending_rsp [$];
      int         errors;

      function new();
         sys_time = 0; cur_slot = 0; thread_cnt = 0; id_cnt = 0; evt_cnt = 0; errors = 0;
         for (int i = 0; i < 16; i++) begin
            alive[i] = 0; asleep[i] = 0; blocked[i] = 0; prio[i] = 0; wake[i] = 0;
            ident[i] = 0;
         end
         for (int i = 0; i < 8; i++) begin
            evt_period[i] = 0; evt_due[i] = 0;
         end
      endfunction

      function void push(pts_pkg::status_type st, bit [19:0] asg, bit fired, bit [2:0] evi,
                         bit sw, bit lst);
         sched_rsp_type r;
         r.status = st; r.running_slot = cur_slot; r.running_id = ident[cur_slot];
         r.assigned_id = asg; r.event_fired = fired; r.event_index = evi;
         r.switch_request = sw; r.last = lst;
         pending_rsp.push_back(r);
      endfunction

      function int find_alive(bit [19:0] id);
         int hit;
         hit = -1;
         for (int i = 0; i < 16; i++)
            if (alive[i] && ident[i] == id) hit = i;
         return hit;
      endfunction

      // note an accepted request and queue its responses
      function void note_request(pts_pkg::req_code_type rt, bit [7:0] pv, bit [19:0] tid,
                                 bit bv, bit [31:0] st, bit [31:0] pt);
         int s;
         bit [7:0] best;
         bit [3:0] c;
         case (rt)
            pts_pkg::REQ_TICK: begin
               sys_time++;
               for (int e = 0; e < evt_cnt; e++)
                  if (evt_due[e] == sys_time) begin
                     evt_due[e] = evt_period[e] + sys_time;
                     push(pts_pkg::ST_OK, 0, 1, e[2:0], 0, 0);
                  end
               for (int i = 0; i < 16; i++)
                  if (alive[i] && asleep[i] && wake[i] == sys_time) begin
                     asleep[i] = 0; wake[i] = 0;
                  end
               push(pts_pkg::ST_OK, 0, 0, 0, 1, 1);
            end
            pts_pkg::REQ_SCHED: begin
               best = pts_pkg::PRIO_BOUND; c = cur_slot;
               for (int off = 1; off <= 16; off++) begin
                  s = (c + off) % 16;
                  if (alive[s] && !asleep[s] && !blocked[s] && prio[s] < best) begin
                     best = prio[s]; cur_slot = 4'(s);
                  end
               end
               push(pts_pkg::ST_OK, 0, 0, 0, 0, 1);
            end
            pts_pkg::REQ_ADD: begin
               s = -1;
               if (thread_cnt < 16)
                  for (int i = 0; i < 16 && s < 0; i++)
                     if (!alive[i]) s = i;
               if (s < 0) push(pts_pkg::ST_FULL, 0, 0, 0, 0, 1);
               else begin
                  alive[s] = 1; asleep[s] = 0; blocked[s] = 0; wake[s] = 0; prio[s] = pv;
                  ident[s] = {id_cnt, 4'(s)};
                  id_cnt++; thread_cnt++;
                  push(pts_pkg::ST_OK, ident[s], 0, 0, 0, 1);
               end
            end
            pts_pkg::REQ_KILL: begin
               if (thread_cnt <= 1) push(pts_pkg::ST_LAST, 0, 0, 0, 0, 1);
               else begin
                  s = find_alive(tid);
                  if (s < 0) push(pts_pkg::ST_NONE, 0, 0, 0, 0, 1);
                  else begin
                     alive[s] = 0; thread_cnt--;
                     push(pts_pkg::ST_OK, 0, 0, 0, ident[cur_slot] == tid, 1);
                  end
               end
            end
            pts_pkg::REQ_KSELF: begin
               if (thread_cnt <= 1) push(pts_pkg::ST_LAST, 0, 0, 0, 0, 1);
               else if (!alive[cur_slot]) push(pts_pkg::ST_NONE, 0, 0, 0, 0, 1);
               else begin
                  alive[cur_slot] = 0; thread_cnt--;
                  push(pts_pkg::ST_OK, 0, 0, 0, 1, 1);
               end
            end
            pts_pkg::REQ_SLEEP: begin
               asleep[cur_slot] = 1; wake[cur_slot] = st + sys_time;
               push(pts_pkg::ST_OK, 0, 0, 0, 1, 1);
            end
            pts_pkg::REQ_BLOCK: begin
               s = find_alive(tid);
               if (s < 0) push(pts_pkg::ST_NONE, 0, 0, 0, 0, 1);
               else begin
                  blocked[s] = bv;
                  push(pts_pkg::ST_OK, 0, 0, 0, 0, 1);
               end
            end
            default: begin
               if (evt_cnt >= 8) push(pts_pkg::ST_FULL, 0, 0, 0, 0, 1);
               else begin
                  evt_period[evt_cnt] = pt; evt_due[evt_cnt] = sys_time + 1;
                  push(pts_pkg::ST_OK, 0, 0, 3'(evt_cnt), 0, 1);
                  evt_cnt++;
               end
            end
         endcase
      endfunction

      // one line per mismatch, counted
      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // compare one response with the oldest expectation
      task check_response(sched_rsp_type got);
         sched_rsp_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected response %p", got));
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (got !== exp_rsp) begin
            report($sformatf("got %p exp %p", got, exp_rsp));
         end
      endtask
   endclass
endpackage

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// top of the priority thread scheduler testbench
module testbench;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;

   pts_req_if req_bus ();
   pts_rsp_if rsp_bus ();

   pts_tb_pkg::sched_scoreboard board;
   bit        hold_off = 0;
   int        idle_cycles = 0;

   always #5 clock = ~clock;

   priority_thread_scheduler u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   initial begin
      board = new();
      req_bus.valid = 0;
      req_bus.req_type = pts_pkg::REQ_TICK;
      req_bus.prio_value = 0;
      req_bus.target_id = 0;
      req_bus.block_value = 0;
      req_bus.sleep_ticks = 0;
      req_bus.period_ticks = 0;
      rsp_bus.ready = 0;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.note_request(pts_pkg::req_code_type'(req_bus.req_type),
                               req_bus.prio_value, req_bus.target_id,
                               req_bus.block_value, req_bus.sleep_ticks,
                               req_bus.period_ticks);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_response({rsp_bus.status, rsp_bus.running_slot,
                                  rsp_bus.running_id, rsp_bus.assigned_id,
                                  rsp_bus.event_fired, rsp_bus.event_index,
                                  rsp_bus.switch_request, rsp_bus.last});
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("testbench NOT OK");
         $finish;
      end
   end

   // receiver stall pattern: quiet stretches, bursty stalls, one long hold-off
   initial begin
      int phase;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         phase = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            @(negedge clock);
            if (hold_off) rsp_bus.ready <= 0;
            else if (phase == 0) rsp_bus.ready <= 1;
            else rsp_bus.ready <= ($urandom_range(0, phase) == 0);
         end
      end
   end

   // pick an identifier: mostly a live one, sometimes a stale or random one
   function automatic bit [19:0] pick_id();
      int s;
      s = $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0) return 20'($urandom);
      if (board.ident[s] == 0 && !board.alive[s]) return 20'($urandom_range(0, 15));
      return board.ident[s];
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_request(pts_pkg::req_code_type rt, bit [7:0] pv, bit [19:0] tid,
                               bit bv, bit [31:0] st, bit [31:0] pt);
      req_bus.valid <= 1;
      req_bus.req_type <= rt;
      req_bus.prio_value <= pv;
      req_bus.target_id <= tid;
      req_bus.block_value <= bv;
      req_bus.sleep_ticks <= st;
      req_bus.period_ticks <= pt;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_bus.valid <= 0;
      repeat (n) @(negedge clock);
   endtask

   // random request with content shaped toward the interesting cases
   task automatic send_random();
      pts_pkg::req_code_type rt;
      int sel;
      bit [31:0] st;
      sel = $urandom_range(0, 99);
      if (sel < 15) rt = pts_pkg::REQ_TICK;
      else if (sel < 40) rt = pts_pkg::REQ_SCHED;
      else if (sel < 58) rt = pts_pkg::REQ_ADD;
      else if (sel < 66) rt = pts_pkg::REQ_KILL;
      else if (sel < 71) rt = pts_pkg::REQ_KSELF;
      else if (sel < 78) rt = pts_pkg::REQ_SLEEP;
      else if (sel < 93) rt = pts_pkg::REQ_BLOCK;
      else rt = pts_pkg::REQ_PERIOD;
      // sleep mostly short so sleepers wake, sometimes full range
      st = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
      send_request(rt, ($urandom_range(0, 5) == 0) ? 8'hff : 8'($urandom),
                   pick_id(), $urandom_range(0, 1), st,
                   ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 5));
   endtask

   initial begin
      bit [31:0] ones;
      ones = '1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: errors on an empty table, then extremes of every field
      send_request(pts_pkg::REQ_KILL, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_KSELF, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_BLOCK, 0, 20'hfffff, 1, 0, 0);
      send_request(pts_pkg::REQ_ADD, 8'hff, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_SCHED, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_ADD, 8'h00, 20'hfffff, 1, ones, ones);
      send_request(pts_pkg::REQ_ADD, 8'h80, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_SCHED, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_BLOCK, 0, board.ident[1], 1, 0, 0);
      send_request(pts_pkg::REQ_SCHED, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_BLOCK, 0, board.ident[1], 0, 0, 0);
      send_request(pts_pkg::REQ_PERIOD, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_PERIOD, 0, 0, 0, 0, ones);
      send_request(pts_pkg::REQ_PERIOD, 0, 0, 0, 0, 1);
      send_request(pts_pkg::REQ_TICK, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_TICK, 0, 0, 0, 0, 0);
      // sleep of zero length, then of one tick
      send_request(pts_pkg::REQ_SLEEP, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_SLEEP, 0, 0, 0, 1, 0);
      send_request(pts_pkg::REQ_TICK, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_KILL, 0, board.ident[board.cur_slot], 0, 0, 0);
      // killed current slot: kill self reports no such thread
      send_request(pts_pkg::REQ_KSELF, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_SCHED, 0, 0, 0, 0, 0);
      send_request(pts_pkg::REQ_KILL, 0, 20'h12345, 0, 0, 0);
      // fill both tables to capacity
      repeat (17) send_request(pts_pkg::REQ_ADD, 8'($urandom), 0, 0, 0, 0);
      repeat (6) send_request(pts_pkg::REQ_PERIOD, 0, 0, 0, 0, $urandom_range(0, 3));

      // long receiver hold-off while requests keep coming
      hold_off = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         repeat (6) send_random();
      join

      // random bursts with gaps
      for (int n = 0; n < 250;) begin
         repeat ($urandom_range(1, 12)) begin
            send_random();
            n++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 25));
      end
      req_bus.valid <= 0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending_rsp.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/pts_pkg.sv
hdl/pts_req_if.sv
hdl/pts_rsp_if.sv
hdl/priority_thread_scheduler.sv
verif/pts_tb_pkg.sv
verif/testbench.sv
